// File: design/tchp_pkg.sv
// ----------------------------------------------------------------------------
// tchp_pkg
// shared types, record codes and size tables for the tensor container parser
// ----------------------------------------------------------------------------
package tchp_pkg;

    // record kinds
    localparam logic [2:0] REC_HEADER = 3'd0;
    localparam logic [2:0] REC_META   = 3'd1;
    localparam logic [2:0] REC_TENSOR = 3'd2;
    localparam logic [2:0] REC_START  = 3'd3;
    localparam logic [2:0] REC_ERROR  = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ERR_EARLY_END = 2'd2;

    localparam logic [31:0] FILE_MAGIC = 32'h4655_4747;
    localparam logic [31:0] VT_STRING  = 32'd8;
    localparam logic [31:0] VT_ARRAY   = 32'd9;
    localparam logic [31:0] VER_TWO    = 32'd2;
    localparam logic [31:0] VER_THREE  = 32'd3;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  err;
        logic [31:0] version;
        logic        vknown;
        logic [63:0] first;
        logic [63:0] second;
        logic [31:0] kcode;
        logic [31:0] akind;
        logic [63:0] scalar;
        logic [63:0] offset;
    } t_rec;

    // bytes taken by a scalar metadata value, zero for other types
    function automatic logic [3:0] scalar_size(logic [31:0] t);
        logic [3:0] s;
        case (t)
            32'd0, 32'd1, 32'd7:    s = 4'd1;
            32'd2, 32'd3:           s = 4'd2;
            32'd4, 32'd5, 32'd6:    s = 4'd4;
            32'd10, 32'd11, 32'd12: s = 4'd8;
            default:                s = 4'd0;
        endcase
        return s;
    endfunction

    // tensor size in bytes, block types round up to started blocks of 256
    function automatic logic [63:0] tensor_bytes(logic [31:0] t, logic [63:0] n);
        logic [63:0] blocks;
        logic [63:0] sz;
        blocks = (n >> 8) + {63'd0, (n[7:0] != 8'd0)};
        case (t)
            32'd0, 32'd26:  sz = n << 2;
            32'd1, 32'd25:  sz = n << 1;
            32'd24:         sz = n;
            32'd27, 32'd28: sz = n << 3;
            32'd10:         sz = blocks << 6;
            32'd12:         sz = (blocks << 6) + (blocks << 5);
            32'd14:         sz = blocks << 7;
            32'd2, 32'd3, 32'd6, 32'd7, 32'd8, 32'd9, 32'd11, 32'd13, 32'd15:
                            sz = n;
            default:        sz = 64'd0;
        endcase
        return sz;
    endfunction

endpackage

// File: design/tchp_front.sv
// ----------------------------------------------------------------------------
// tchp_front
// byte-serial parser: gathers fields, walks the file structure, makes records
// ----------------------------------------------------------------------------
module tchp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output logic          o_push,
    output tchp_pkg::t_rec o_rec
);
    import tchp_pkg::*;

    typedef enum logic [22:0] {
        PH_MAGIC     = 23'b1 << 0,
        PH_VERSION   = 23'b1 << 1,
        PH_NTENS     = 23'b1 << 2,
        PH_NKV       = 23'b1 << 3,
        PH_KEYLEN    = 23'b1 << 4,
        PH_KEYSKIP   = 23'b1 << 5,
        PH_VTYPE     = 23'b1 << 6,
        PH_SCALAR    = 23'b1 << 7,
        PH_STRLEN    = 23'b1 << 8,
        PH_STRSKIP   = 23'b1 << 9,
        PH_ARRTYPE   = 23'b1 << 10,
        PH_ARRCOUNT  = 23'b1 << 11,
        PH_ELEMSKIP  = 23'b1 << 12,
        PH_ELEMSTRLEN= 23'b1 << 13,
        PH_NAMELEN   = 23'b1 << 14,
        PH_NAMESKIP  = 23'b1 << 15,
        PH_NDIMS     = 23'b1 << 16,
        PH_DIM       = 23'b1 << 17,
        PH_TTYPE     = 23'b1 << 18,
        PH_TOFFSET   = 23'b1 << 19,
        PH_PENDING   = 23'b1 << 20,
        PH_DONE      = 23'b1 << 21,
        PH_DEAD      = 23'b1 << 22
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [63:0] r_shift, n_shift;
    logic [63:0] r_pos, n_pos;
    logic [63:0] r_entries, n_entries;
    logic [63:0] r_tensors, n_tensors;
    logic [63:0] r_array, n_array;
    logic [63:0] r_skip, n_skip;
    logic [31:0] r_dims, n_dims;
    logic [31:0] r_type, n_type;
    logic [63:0] r_hdr0, n_hdr0;
    logic [63:0] r_hdr1, n_hdr1;
    logic [31:0] r_magic, n_magic;
    logic [31:0] r_version, n_version;
    logic [63:0] r_keylen, n_keylen;
    logic [63:0] r_vcount, n_vcount;
    logic [31:0] r_ekind, n_ekind;
    logic [63:0] r_scalar, n_scalar;
    logic [31:0] r_dimcount, n_dimcount;

    // shared 32x32 multiplier folds each dimension into the element product
    logic [63:0] r_prod;
    logic [63:0] r_mul_a, r_mul_b;
    logic [63:0] r_p0;
    logic [31:0] r_p1, r_p2;
    logic [1:0]  r_mul_step;
    logic        r_mul_busy;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_out;
    logic        mul_start, prod_reset;

    logic        g_act, g_done;
    logic [3:0]  g_nb, idx_inc;
    logic [63:0] g_val;
    logic        do_start, do_elem_done, do_finish, do_next;
    logic [3:0]  ss;
    t_rec        rec;
    logic        push;

    function automatic t_phase next_sec(logic [63:0] e, logic [63:0] t);
        t_phase p;
        if (e != 64'd0) begin
            p = PH_KEYLEN;
        end else if (t != 64'd0) begin
            p = PH_NAMELEN;
        end else begin
            p = PH_PENDING;
        end
        return p;
    endfunction

    // field gatherer
    always_comb begin
        g_act = 1'b1;
        g_nb  = 4'd8;
        case (r_phase)
            PH_MAGIC, PH_VERSION, PH_VTYPE, PH_ARRTYPE, PH_NDIMS, PH_TTYPE: g_nb = 4'd4;
            PH_NTENS, PH_NKV, PH_KEYLEN, PH_STRLEN, PH_ARRCOUNT, PH_ELEMSTRLEN,
            PH_NAMELEN, PH_DIM, PH_TOFFSET: g_nb = 4'd8;
            PH_SCALAR: g_nb = scalar_size(r_type);
            default: g_act = 1'b0;
        endcase
        idx_inc = r_idx + 4'd1;
        g_val   = r_shift | ({56'd0, i_data_byte} << {r_idx[2:0], 3'b000});
        g_done  = (idx_inc >= g_nb);
    end

    always_comb begin
        n_phase = r_phase;     n_idx = r_idx;         n_shift = r_shift;
        n_pos = r_pos + 64'd1; n_entries = r_entries; n_tensors = r_tensors;
        n_array = r_array;     n_skip = r_skip;       n_dims = r_dims;
        n_type = r_type;       n_hdr0 = r_hdr0;       n_hdr1 = r_hdr1;
        n_magic = r_magic;     n_version = r_version; n_keylen = r_keylen;
        n_vcount = r_vcount;   n_ekind = r_ekind;     n_scalar = r_scalar;
        n_dimcount = r_dimcount;
        do_start = 1'b0; do_elem_done = 1'b0; do_finish = 1'b0; do_next = 1'b0;
        mul_start = 1'b0; prod_reset = 1'b0;
        rec = '0; push = 1'b0; ss = 4'd0;

        if (g_act) begin
            if (g_done) begin
                n_shift = 64'd0;
                n_idx   = 4'd0;
            end else begin
                n_shift = g_val;
                n_idx   = idx_inc;
            end
        end

        case (r_phase)
            PH_MAGIC: begin
                if (g_done) begin
                    n_magic = g_val[31:0];
                    n_phase = PH_VERSION;
                end
            end
            PH_VERSION: begin
                if (g_done) begin
                    n_version = g_val[31:0];
                    n_phase   = PH_NTENS;
                end
            end
            PH_NTENS: begin
                if (g_done) begin
                    n_hdr0  = g_val;
                    n_phase = PH_NKV;
                end
            end
            PH_NKV: begin
                if (g_done) begin
                    n_hdr1 = g_val;
                    push   = 1'b1;
                    if (r_magic != FILE_MAGIC) begin
                        rec.kind = REC_ERROR;
                        rec.err  = ERR_BAD_MAGIC;
                        n_phase  = PH_DEAD;
                    end else begin
                        rec.kind    = REC_HEADER;
                        rec.version = r_version;
                        rec.vknown  = (r_version == VER_TWO) || (r_version == VER_THREE);
                        rec.first   = r_hdr0;
                        rec.second  = g_val;
                        n_tensors   = r_hdr0;
                        n_entries   = g_val;
                        do_next     = 1'b1;
                    end
                end
            end
            PH_KEYLEN: begin
                if (g_done) begin
                    n_keylen = g_val;
                    n_vcount = 64'd0;
                    n_ekind  = 32'd0;
                    n_scalar = 64'd0;
                    n_skip   = g_val;
                    n_phase  = (g_val != 64'd0) ? PH_KEYSKIP : PH_VTYPE;
                end
            end
            PH_KEYSKIP: begin
                n_skip = r_skip - 64'd1;
                if (n_skip == 64'd0) begin
                    n_phase = PH_VTYPE;
                end
            end
            PH_VTYPE: begin
                if (g_done) begin
                    n_type = g_val[31:0];
                    if (scalar_size(g_val[31:0]) != 4'd0) begin
                        n_phase = PH_SCALAR;
                    end else if (g_val[31:0] == VT_STRING) begin
                        n_phase = PH_STRLEN;
                    end else if (g_val[31:0] == VT_ARRAY) begin
                        n_phase = PH_ARRTYPE;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_SCALAR: begin
                if (g_done) begin
                    n_scalar  = g_val;
                    do_finish = 1'b1;
                end
            end
            PH_STRLEN: begin
                if (g_done) begin
                    n_vcount = g_val;
                    n_skip   = g_val;
                    if (g_val == 64'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        n_phase = PH_STRSKIP;
                    end
                end
            end
            PH_STRSKIP: begin
                n_skip = r_skip - 64'd1;
                if (n_skip == 64'd0) begin
                    do_finish = 1'b1;
                end
            end
            PH_ARRTYPE: begin
                if (g_done) begin
                    n_ekind = g_val[31:0];
                    n_phase = PH_ARRCOUNT;
                end
            end
            PH_ARRCOUNT: begin
                if (g_done) begin
                    n_vcount = g_val;
                    n_array  = g_val;
                    do_start = 1'b1;
                end
            end
            PH_ELEMSKIP: begin
                n_skip = r_skip - 64'd1;
                if (n_skip == 64'd0) begin
                    do_elem_done = 1'b1;
                end
            end
            PH_ELEMSTRLEN: begin
                if (g_done) begin
                    n_skip = g_val;
                    if (g_val == 64'd0) begin
                        do_elem_done = 1'b1;
                    end else begin
                        n_phase = PH_ELEMSKIP;
                    end
                end
            end
            PH_NAMELEN: begin
                if (g_done) begin
                    n_skip  = g_val;
                    n_phase = (g_val != 64'd0) ? PH_NAMESKIP : PH_NDIMS;
                end
            end
            PH_NAMESKIP: begin
                n_skip = r_skip - 64'd1;
                if (n_skip == 64'd0) begin
                    n_phase = PH_NDIMS;
                end
            end
            PH_NDIMS: begin
                if (g_done) begin
                    n_dimcount = g_val[31:0];
                    n_dims     = g_val[31:0];
                    prod_reset = 1'b1;
                    n_phase    = (g_val[31:0] != 32'd0) ? PH_DIM : PH_TTYPE;
                end
            end
            PH_DIM: begin
                if (g_done) begin
                    mul_start = 1'b1;
                    n_dims    = r_dims - 32'd1;
                    if (n_dims == 32'd0) begin
                        n_phase = PH_TTYPE;
                    end
                end
            end
            PH_TTYPE: begin
                if (g_done) begin
                    n_type  = g_val[31:0];
                    n_phase = PH_TOFFSET;
                end
            end
            PH_TOFFSET: begin
                if (g_done) begin
                    push        = 1'b1;
                    rec.kind    = REC_TENSOR;
                    rec.first   = {32'd0, r_dimcount};
                    rec.second  = r_prod;
                    rec.kcode   = r_type;
                    rec.offset  = g_val;
                    n_tensors   = r_tensors - 64'd1;
                    n_phase     = (n_tensors != 64'd0) ? PH_NAMELEN : PH_PENDING;
                end
            end
            PH_PENDING: begin
                push       = 1'b1;
                rec.kind   = REC_START;
                rec.offset = (r_pos + 64'd63) & ~64'd63;
                n_phase    = PH_DONE;
            end
            default: begin
            end
        endcase

        // array element walk
        if (do_elem_done) begin
            n_array  = n_array - 64'd1;
            do_start = 1'b1;
        end
        if (do_start) begin
            ss = scalar_size(n_ekind);
            if (n_array == 64'd0) begin
                do_finish = 1'b1;
            end else if (ss != 4'd0) begin
                n_skip  = {60'd0, ss};
                n_phase = PH_ELEMSKIP;
            end else if (n_ekind == VT_STRING) begin
                n_phase = PH_ELEMSTRLEN;
            end else begin
                do_finish = 1'b1;
            end
        end
        if (do_finish) begin
            push        = 1'b1;
            rec.kind    = REC_META;
            rec.first   = n_keylen;
            rec.second  = n_vcount;
            rec.kcode   = n_type;
            rec.akind   = n_ekind;
            rec.scalar  = n_scalar;
            n_entries   = n_entries - 64'd1;
            do_next     = 1'b1;
        end
        if (do_next) begin
            n_phase = next_sec(n_entries, n_tensors);
        end

        // end of file: error if incomplete, then restart
        if (i_last_byte) begin
            if (n_phase != PH_PENDING && n_phase != PH_DONE && n_phase != PH_DEAD) begin
                push     = 1'b1;
                rec      = '0;
                rec.kind = REC_ERROR;
                rec.err  = ERR_EARLY_END;
            end
            n_phase = PH_MAGIC;   n_idx = 4'd0;       n_shift = 64'd0;
            n_pos = 64'd0;        n_entries = 64'd0;  n_tensors = 64'd0;
            n_array = 64'd0;      n_skip = 64'd0;     n_dims = 32'd0;
            n_type = 32'd0;       n_hdr0 = 64'd0;     n_hdr1 = 64'd0;
            n_magic = 32'd0;      n_version = 32'd0;  n_keylen = 64'd0;
            n_vcount = 64'd0;     n_ekind = 32'd0;    n_scalar = 64'd0;
            n_dimcount = 32'd0;
            mul_start = 1'b0;
            prod_reset = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;  r_idx <= 4'd0;       r_shift <= 64'd0;
            r_pos <= 64'd0;       r_entries <= 64'd0;  r_tensors <= 64'd0;
            r_array <= 64'd0;     r_skip <= 64'd0;     r_dims <= 32'd0;
            r_type <= 32'd0;      r_hdr0 <= 64'd0;     r_hdr1 <= 64'd0;
            r_magic <= 32'd0;     r_version <= 32'd0;  r_keylen <= 64'd0;
            r_vcount <= 64'd0;    r_ekind <= 32'd0;    r_scalar <= 64'd0;
            r_dimcount <= 32'd0;
        end else if (i_en) begin
            r_phase <= n_phase;   r_idx <= n_idx;         r_shift <= n_shift;
            r_pos <= n_pos;       r_entries <= n_entries; r_tensors <= n_tensors;
            r_array <= n_array;   r_skip <= n_skip;       r_dims <= n_dims;
            r_type <= n_type;     r_hdr0 <= n_hdr0;       r_hdr1 <= n_hdr1;
            r_magic <= n_magic;   r_version <= n_version; r_keylen <= n_keylen;
            r_vcount <= n_vcount; r_ekind <= n_ekind;     r_scalar <= n_scalar;
            r_dimcount <= n_dimcount;
        end
    end

    // product low 64 bits: a_lo*b_lo + ((a_lo*b_hi + a_hi*b_lo) << 32)
    always_comb begin
        case (r_mul_step)
            2'd0:    begin mul_x = r_mul_a[31:0];  mul_y = r_mul_b[31:0];  end
            2'd1:    begin mul_x = r_mul_a[31:0];  mul_y = r_mul_b[63:32]; end
            default: begin mul_x = r_mul_a[63:32]; mul_y = r_mul_b[31:0];  end
        endcase
        mul_out = {32'd0, mul_x} * {32'd0, mul_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod     <= 64'd1;
            r_mul_busy <= 1'b0;
            r_mul_step <= 2'd0;
        end else if (i_en && prod_reset) begin
            r_prod     <= 64'd1;
            r_mul_busy <= 1'b0;
            r_mul_step <= 2'd0;
        end else if (i_en && mul_start) begin
            r_mul_a    <= r_prod;
            r_mul_b    <= g_val;
            r_mul_busy <= 1'b1;
            r_mul_step <= 2'd0;
        end else if (r_mul_busy) begin
            case (r_mul_step)
                2'd0:    r_p0 <= mul_out;
                2'd1:    r_p1 <= mul_out[31:0];
                2'd2:    r_p2 <= mul_out[31:0];
                default: begin
                    r_prod     <= r_p0 + {r_p1 + r_p2, 32'd0};
                    r_mul_busy <= 1'b0;
                end
            endcase
            r_mul_step <= r_mul_step + 2'd1;
        end
    end

    assign o_push = i_en && push;
    assign o_rec  = rec;

endmodule

// File: design/tchp_queue.sv
// ----------------------------------------------------------------------------
// tchp_queue
// short record queue between parser and output stage
// ----------------------------------------------------------------------------
module tchp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tchp_pkg::t_rec i_rec,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tchp_pkg::t_rec o_rec
);
    import tchp_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    t_rec          r_mem [QDEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    assign o_full  = (r_count == (AW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];

endmodule

// File: design/tchp_back.sv
// ----------------------------------------------------------------------------
// tchp_back
// output stage: sizes tensor records and holds the result for the consumer
// ----------------------------------------------------------------------------
module tchp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  tchp_pkg::t_rec i_q_rec,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output tchp_pkg::t_rec o_rec,
    output logic [63:0]    o_byte_size
);
    import tchp_pkg::*;

    logic        r_valid;
    t_rec        r_rec;
    logic [63:0] r_size;
    logic [63:0] n_size;

    assign o_pop  = i_q_valid && (!r_valid || !i_stall);
    assign n_size = (i_q_rec.kind == REC_TENSOR) ?
                    tensor_bytes(i_q_rec.kcode, i_q_rec.second) : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec  <= i_q_rec;
            r_size <= n_size;
        end
    end

    assign o_valid     = r_valid;
    assign o_rec       = r_rec;
    assign o_byte_size = r_size;

endmodule

// File: design/tensor_container_header_parser.sv
// ----------------------------------------------------------------------------
// tensor_container_header_parser
// byte-stream parser for tensor container file headers and descriptors
// ----------------------------------------------------------------------------
// Takes one file byte per transfer and sustains one byte per clock while the
// queue has room. Each byte is handled in the cycle it is accepted. Records
// then pass through a two-entry queue into an output register: a record is
// written to the queue by the edge that accepts the byte that completes it and
// is then popped into the output register. The input stalls only when both
// queue entries are occupied behind a stalled output. Per file it emits one
// header record, one record per metadata entry, one per tensor descriptor and
// the 64-byte aligned data start on the byte after the last descriptor, or an
// error record on bad magic or on a last byte that ends the structure early.
// Element counts are folded by a shared 32x32 multiplier, which forms the
// partial products and always sums them before the next eight-byte dimension arrives.
// ----------------------------------------------------------------------------
module tensor_container_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // record output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_record_kind,
    output logic [1:0]  o_error_code,
    output logic [31:0] o_format_version,
    output logic        o_version_known,
    output logic [63:0] o_first_count,
    output logic [63:0] o_second_count,
    output logic [31:0] o_kind_code,
    output logic [31:0] o_array_elem_kind,
    output logic [63:0] o_scalar_bits,
    output logic [63:0] o_offset_value,
    output logic [63:0] o_byte_size
);
    import tchp_pkg::*;

    logic q_full, q_valid, q_pop, f_push, en;
    t_rec f_rec, q_rec, b_rec;

    // a byte transfer happens whenever a byte is offered and the queue has room
    assign o_stall = q_full;
    assign en      = i_valid && !q_full;

    // front: field gathering and structure walk
    tchp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (f_push),
        .o_rec       (f_rec)
    );

    // queue decouples parsing from output stalls
    tchp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_rec   (f_rec),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    // back: tensor size and output register
    tchp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_rec     (q_rec),
        .o_pop       (q_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_rec       (b_rec),
        .o_byte_size (o_byte_size)
    );

    assign o_record_kind     = b_rec.kind;
    assign o_error_code      = b_rec.err;
    assign o_format_version  = b_rec.version;
    assign o_version_known   = b_rec.vknown;
    assign o_first_count     = b_rec.first;
    assign o_second_count    = b_rec.second;
    assign o_kind_code       = b_rec.kcode;
    assign o_array_elem_kind = b_rec.akind;
    assign o_scalar_bits     = b_rec.scalar;
    assign o_offset_value    = b_rec.offset;

endmodule

// File: design/tchp_checker.sv
// ----------------------------------------------------------------------------
// tchp_checker
// port-level checks for the tensor container parser
// ----------------------------------------------------------------------------
module tchp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_record_kind,
    input logic [1:0]  o_error_code,
    input logic [63:0] o_offset_value,
    input logic [63:0] o_byte_size
);
    import tchp_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_record_kind) && $stable(o_byte_size))
        else $error("stalled result changed");

    // error code only on error records
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind != REC_ERROR |-> o_error_code == ERR_NONE)
        else $error("error code on a non-error record");

    // data start is 64-byte aligned
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == REC_START |-> o_offset_value[5:0] == 6'd0)
        else $error("data start not aligned");

    // only tensor records carry a size
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind != REC_TENSOR |-> o_byte_size == 64'd0)
        else $error("byte size on a non-tensor record");

endmodule

bind tensor_container_header_parser tchp_checker u_tchp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_record_kind  (o_record_kind),
    .o_error_code   (o_error_code),
    .o_offset_value (o_offset_value),
    .o_byte_size    (o_byte_size)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tensor container header parser
// ----------------------------------------------------------------------------
// Builds container files byte by byte and sends them through the byte port.
// Most files are well formed with random content. The rest have bad magic,
// end early, carry huge counts or are plain noise. A behavioral parser in the
// bench tracks every accepted byte and queues the record that byte should
// produce. The monitor compares each record field by field with the oldest
// queued record. Sender gaps and receiver stalls run in three phases.
// ----------------------------------------------------------------------------
module tb;
    import tchp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  err;
        logic [31:0] version;
        logic        vknown;
        logic [63:0] first;
        logic [63:0] second;
        logic [31:0] kcode;
        logic [31:0] akind;
        logic [63:0] scalar;
        logic [63:0] offset;
        logic [63:0] size;
    } record_t;

    typedef enum logic [4:0] {
        P_MAGIC, P_VERSION, P_NTENS, P_NKV,
        P_KEYLEN, P_KEYSKIP, P_VTYPE, P_SCALAR, P_STRLEN, P_STRSKIP,
        P_ARRTYPE, P_ARRCOUNT, P_ELEMSKIP, P_ELEMSTRLEN,
        P_NAMELEN, P_NAMESKIP, P_NDIMS, P_DIM, P_TTYPE, P_TOFFSET,
        P_PENDING, P_DONE, P_DEAD
    } phase_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_record_kind;
    logic [1:0]  o_error_code;
    logic [31:0] o_format_version;
    logic        o_version_known;
    logic [63:0] o_first_count;
    logic [63:0] o_second_count;
    logic [31:0] o_kind_code;
    logic [31:0] o_array_elem_kind;
    logic [63:0] o_scalar_bits;
    logic [63:0] o_offset_value;
    logic [63:0] o_byte_size;

    tensor_container_header_parser dut (.*);

    // file bytes waiting to go out, and records the parser should produce
    byte_t   file_bytes[$];
    record_t record_q[$];
    int      fail_count;
    int      cycle_count;
    int      send_gap_pct;
    int      recv_stall_pct;

    // shadow parser state
    phase_e      phase;
    logic [3:0]  fidx;
    logic [63:0] fshift;
    logic [63:0] spos;
    logic [63:0] ents_left;
    logic [63:0] tens_left;
    logic [63:0] arr_left;
    logic [63:0] skip_left;
    logic [31:0] dims_left;
    logic [63:0] elem_prod;
    logic [31:0] cur_type;
    logic [63:0] hdr_tensors;
    logic [63:0] hdr_entries;
    logic [31:0] magic_w;
    logic [31:0] version_w;
    logic [63:0] key_len;
    logic [63:0] val_count;
    logic [31:0] arr_kind;
    logic [63:0] scalar_v;
    logic [31:0] dim_cnt;
    record_t     rec;
    logic        rec_valid;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // shadow parser
    // ------------------------------------------------------------------------
    function void parser_clear();
        phase = P_MAGIC;
        fidx = '0;
        fshift = '0;
        spos = '0;
        ents_left = '0;
        tens_left = '0;
        arr_left = '0;
        skip_left = '0;
        dims_left = '0;
        elem_prod = 64'd1;
        cur_type = '0;
        hdr_tensors = '0;
        hdr_entries = '0;
        magic_w = '0;
        version_w = '0;
        key_len = '0;
        val_count = '0;
        arr_kind = '0;
        scalar_v = '0;
        dim_cnt = '0;
    endfunction

    // little-endian field assembly, returns 1 once n bytes are in
    function bit take_field(input logic [7:0] b, input int n, output logic [63:0] v);
        fshift = fshift | ({56'd0, b} << (8 * fidx[2:0]));
        fidx = fidx + 4'd1;
        v = fshift;
        if (int'(fidx) < n)
            return 1'b0;
        fshift = '0;
        fidx = '0;
        return 1'b1;
    endfunction

    function int value_bytes(input logic [31:0] t);
        if (t == 0 || t == 1 || t == 7) return 1;
        if (t == 2 || t == 3) return 2;
        if (t == 4 || t == 5 || t == 6) return 4;
        if (t == 10 || t == 11 || t == 12) return 8;
        return 0;
    endfunction

    function logic [63:0] desc_bytes(input logic [31:0] t, input logic [63:0] n);
        logic [63:0] blk;
        case (t)
            0, 26: return n * 4;
            1, 25: return n * 2;
            24: return n;
            27, 28: return n * 8;
            10: blk = 64;
            12: blk = 96;
            14: blk = 128;
            2, 3, 6, 7, 8, 9, 11, 13, 15: return n;
            default: return 64'd0;
        endcase
        return (n / 256) * blk + (((n % 256) != 0) ? blk : 64'd0);
    endfunction

    function void open_record(input logic [2:0] k);
        rec = '0;
        rec.kind = k;
        rec_valid = 1'b1;
    endfunction

    function void pick_section();
        if (ents_left != 0) phase = P_KEYLEN;
        else if (tens_left != 0) phase = P_NAMELEN;
        else phase = P_PENDING;
    endfunction

    function void close_entry();
        open_record(REC_META);
        rec.first = key_len;
        rec.second = val_count;
        rec.kcode = cur_type;
        rec.akind = arr_kind;
        rec.scalar = scalar_v;
        ents_left = ents_left - 1;
        pick_section();
    endfunction

    function void next_element();
        if (arr_left == 0) close_entry();
        else if (value_bytes(arr_kind) != 0) begin
            skip_left = value_bytes(arr_kind);
            phase = P_ELEMSKIP;
        end else if (arr_kind == VT_STRING) phase = P_ELEMSTRLEN;
        else close_entry();
    endfunction

    // one accepted byte; queues the record it causes, if any
    function void parse_byte(input logic [7:0] b, input logic lst);
        logic [63:0] v;
        rec_valid = 1'b0;
        case (phase)
            P_MAGIC: if (take_field(b, 4, v)) begin
                magic_w = v[31:0];
                phase = P_VERSION;
            end
            P_VERSION: if (take_field(b, 4, v)) begin
                version_w = v[31:0];
                phase = P_NTENS;
            end
            P_NTENS: if (take_field(b, 8, v)) begin
                hdr_tensors = v;
                phase = P_NKV;
            end
            P_NKV: if (take_field(b, 8, v)) begin
                hdr_entries = v;
                if (magic_w != FILE_MAGIC) begin
                    open_record(REC_ERROR);
                    rec.err = ERR_BAD_MAGIC;
                    phase = P_DEAD;
                end else begin
                    open_record(REC_HEADER);
                    rec.version = version_w;
                    rec.vknown = (version_w == VER_TWO || version_w == VER_THREE);
                    rec.first = hdr_tensors;
                    rec.second = hdr_entries;
                    tens_left = hdr_tensors;
                    ents_left = hdr_entries;
                    pick_section();
                end
            end
            P_KEYLEN: if (take_field(b, 8, v)) begin
                key_len = v;
                val_count = '0;
                arr_kind = '0;
                scalar_v = '0;
                skip_left = v;
                phase = (v != 0) ? P_KEYSKIP : P_VTYPE;
            end
            P_KEYSKIP: begin
                skip_left = skip_left - 1;
                if (skip_left == 0) phase = P_VTYPE;
            end
            P_VTYPE: if (take_field(b, 4, v)) begin
                cur_type = v[31:0];
                if (value_bytes(cur_type) != 0) phase = P_SCALAR;
                else if (cur_type == VT_STRING) phase = P_STRLEN;
                else if (cur_type == VT_ARRAY) phase = P_ARRTYPE;
                else close_entry();
            end
            P_SCALAR: if (take_field(b, value_bytes(cur_type), v)) begin
                scalar_v = v;
                close_entry();
            end
            P_STRLEN: if (take_field(b, 8, v)) begin
                val_count = v;
                skip_left = v;
                if (v == 0) close_entry();
                else phase = P_STRSKIP;
            end
            P_STRSKIP: begin
                skip_left = skip_left - 1;
                if (skip_left == 0) close_entry();
            end
            P_ARRTYPE: if (take_field(b, 4, v)) begin
                arr_kind = v[31:0];
                phase = P_ARRCOUNT;
            end
            P_ARRCOUNT: if (take_field(b, 8, v)) begin
                val_count = v;
                arr_left = v;
                next_element();
            end
            P_ELEMSKIP: begin
                skip_left = skip_left - 1;
                if (skip_left == 0) begin
                    arr_left = arr_left - 1;
                    next_element();
                end
            end
            P_ELEMSTRLEN: if (take_field(b, 8, v)) begin
                skip_left = v;
                if (v == 0) begin
                    arr_left = arr_left - 1;
                    next_element();
                end else phase = P_ELEMSKIP;
            end
            P_NAMELEN: if (take_field(b, 8, v)) begin
                skip_left = v;
                phase = (v != 0) ? P_NAMESKIP : P_NDIMS;
            end
            P_NAMESKIP: begin
                skip_left = skip_left - 1;
                if (skip_left == 0) phase = P_NDIMS;
            end
            P_NDIMS: if (take_field(b, 4, v)) begin
                dim_cnt = v[31:0];
                dims_left = v[31:0];
                elem_prod = 64'd1;
                phase = (dims_left != 0) ? P_DIM : P_TTYPE;
            end
            P_DIM: if (take_field(b, 8, v)) begin
                elem_prod = elem_prod * v;
                dims_left = dims_left - 1;
                if (dims_left == 0) phase = P_TTYPE;
            end
            P_TTYPE: if (take_field(b, 4, v)) begin
                cur_type = v[31:0];
                phase = P_TOFFSET;
            end
            P_TOFFSET: if (take_field(b, 8, v)) begin
                open_record(REC_TENSOR);
                rec.first = {32'd0, dim_cnt};
                rec.second = elem_prod;
                rec.kcode = cur_type;
                rec.offset = v;
                rec.size = desc_bytes(cur_type, elem_prod);
                tens_left = tens_left - 1;
                phase = (tens_left != 0) ? P_NAMELEN : P_PENDING;
            end
            P_PENDING: begin
                open_record(REC_START);
                rec.offset = (spos + 63) & ~64'd63;
                phase = P_DONE;
            end
            default: ;
        endcase
        spos = spos + 1;
        if (lst) begin
            // last byte while the structure is still open
            if (phase != P_PENDING && phase != P_DONE && phase != P_DEAD) begin
                open_record(REC_ERROR);
                rec.err = ERR_EARLY_END;
            end
            parser_clear();
        end
        if (rec_valid)
            record_q.insert(record_q.size(), rec);
    endfunction

    // ------------------------------------------------------------------------
    // file builder
    // ------------------------------------------------------------------------
    function void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.insert(file_bytes.size(), {v[8*i +: 8], 1'b0});
    endfunction

    function void put_noise(input int n);
        for (int i = 0; i < n; i++)
            put_le($urandom_range(0, 255), 1);
    endfunction

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function void put_value(input logic [31:0] t);
        logic [31:0] et;
        logic [63:0] cnt;
        if (value_bytes(t) != 0) put_le(rand64(), value_bytes(t));
        else if (t == VT_STRING) begin
            cnt = $urandom_range(0, 4);
            put_le(cnt, 8);
            put_noise(cnt);
        end else if (t == VT_ARRAY) begin
            // element kinds include nested arrays and unknown codes
            et = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 14);
            cnt = $urandom_range(0, 3);
            put_le(et, 4);
            put_le(cnt, 8);
            for (int i = 0; i < cnt; i++) begin
                if (value_bytes(et) != 0) put_le(rand64(), value_bytes(et));
                else if (et == VT_STRING) begin
                    int sl;
                    sl = $urandom_range(0, 3);
                    put_le(sl, 8);
                    put_noise(sl);
                end
            end
        end
    endfunction

    // shape: 0 well formed, 1 cut short, 2 bad magic, 3 noise, 4 huge counts
    function void build_file(input int shape, input int n_ent, input int n_ten,
                             input int tail);
        int          start;
        int          kl;
        int          nd;
        logic [31:0] ver;
        logic [31:0] vt;
        logic [63:0] dim;
        start = file_bytes.size();
        if (shape == 3) begin
            put_noise($urandom_range(1, 40));
        end else begin
            case ($urandom_range(0, 3))
                0: ver = VER_TWO;
                1: ver = VER_THREE;
                2: ver = 32'hFFFF_FFFF;
                default: ver = $urandom;
            endcase
            put_le((shape == 2) ? (FILE_MAGIC ^ (32'd1 << $urandom_range(0, 31))) : FILE_MAGIC,
                   4);
            put_le(ver, 4);
            if (shape == 4) begin
                put_le(rand64() | 64'h8000_0000_0000_0000, 8);
                put_le(rand64(), 8);
                put_noise($urandom_range(1, 30));
            end else begin
                put_le(n_ten, 8);
                put_le(n_ent, 8);
                for (int e = 0; e < n_ent; e++) begin
                    kl = $urandom_range(0, 3);
                    put_le(kl, 8);
                    put_noise(kl);
                    vt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 14);
                    put_le(vt, 4);
                    put_value(vt);
                end
                for (int t = 0; t < n_ten; t++) begin
                    kl = $urandom_range(0, 3);
                    put_le(kl, 8);
                    put_noise(kl);
                    nd = $urandom_range(0, 4);
                    put_le(nd, 4);
                    for (int d = 0; d < nd; d++) begin
                        dim = ($urandom_range(0, 7) == 0) ? rand64() : $urandom_range(1, 700);
                        put_le(dim, 8);
                    end
                    put_le(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30), 4);
                    put_le(rand64(), 8);
                end
                put_noise(tail);
            end
        end
        // truncate somewhere inside the file
        if (shape == 1 && file_bytes.size() - start > 1)
            while (file_bytes.size() > start + 1 &&
                   file_bytes.size() > start + $urandom_range(1, 40))
                void'(file_bytes.pop_back());
        file_bytes[file_bytes.size() - 1].last = 1'b1;
    endfunction

    function void random_file();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72)
            build_file(0, $urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 4));
        else if (r < 84)
            build_file(1, $urandom_range(0, 4), $urandom_range(0, 3), 2);
        else if (r < 91)
            build_file(2, $urandom_range(0, 2), $urandom_range(0, 2), 2);
        else if (r < 96)
            build_file(4, 0, 0, 0);
        else
            build_file(3, 0, 0, 0);
    endfunction

    // ------------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                parse_byte(i_data_byte, i_last_byte);
            if (!i_valid || !o_stall) begin
                if (file_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    byte_t nb;
                    nb = file_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= nb.data;
                    i_last_byte <= nb.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // record monitor
    // ------------------------------------------------------------------------
    task report_mismatch(input string field, input logic [63:0] got,
                         input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        fail_count++;
    endtask

    task check_field(input string field, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    always @(posedge i_clk) begin
        record_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (record_q.size() == 0) begin
                    report_mismatch("unexpected record kind", o_record_kind, '0);
                end else begin
                    want = record_q.pop_front();
                    check_field("record_kind", o_record_kind, want.kind);
                    check_field("error_code", o_error_code, want.err);
                    check_field("format_version", o_format_version, want.version);
                    check_field("version_known", o_version_known, want.vknown);
                    check_field("first_count", o_first_count, want.first);
                    check_field("second_count", o_second_count, want.second);
                    check_field("kind_code", o_kind_code, want.kcode);
                    check_field("array_elem_kind", o_array_elem_kind, want.akind);
                    check_field("scalar_bits", o_scalar_bits, want.scalar);
                    check_field("offset_value", o_offset_value, want.offset);
                    check_field("byte_size", o_byte_size, want.size);
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tensor_container_header_parser test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int per_phase;
        fail_count = 0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_stall = 1'b0;
        send_gap_pct = 18;
        recv_stall_pct = 52;
        parser_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty file, entries only, bad magic, early end,
        // last byte on the last descriptor, huge counts, one-byte file
        build_file(0, 0, 0, 3);
        build_file(0, 3, 0, 0);
        build_file(0, 0, 2, 0);
        build_file(2, 1, 1, 1);
        build_file(1, 2, 2, 2);
        build_file(4, 0, 0, 0);
        file_bytes.insert(file_bytes.size(), {8'hFF, 1'b1});

        per_phase = 250;
        for (int p = 0; p < 3; p++) begin
            while (file_bytes.size() < per_phase)
                random_file();
            wait (file_bytes.size() == 0);
            wait (record_q.size() == 0);
            if (p == 0) begin
                send_gap_pct = 52;
                recv_stall_pct = 18;
            end else begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
        end

        @(posedge i_clk);
        wait (!i_valid);
        wait (record_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && record_q.size() == 0)
            $display("tensor_container_header_parser test passed");
        else
            $display("tensor_container_header_parser test failed");
        $finish;
    end

endmodule

// File: files.f
design/tchp_pkg.sv
design/tchp_front.sv
design/tchp_queue.sv
design/tchp_back.sv
design/tensor_container_header_parser.sv
design/tchp_checker.sv
tb/tb.sv
